/* rtl/rasm_pkg.sv */
// Shared types, constants and the sigmoid table for the resistance angle model.
package rasm_pkg;

    localparam int SIG_ENTRIES = 256;
    localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);
    localparam int IDXP_W      = 22 + SIG_IDX_W;
    localparam int ARG_LIMIT   = 524288;
    localparam int DIV_W       = 42;
    localparam int DIV_CNT_W   = $clog2(DIV_W);
    localparam int PADDR_W     = 5;
    localparam int SLOPE_SCALE = 1000000;

    typedef logic [16:0] sig_word_t;
    typedef sig_word_t sig_table_t [SIG_ENTRIES];
    typedef logic [IDXP_W-1:0] idxp_t;
    typedef logic [DIV_W-1:0] div_word_t;

    localparam logic [2:0] REG_BASELINE  = 3'd0;
    localparam logic [2:0] REG_STEEPNESS = 3'd1;
    localparam logic [2:0] REG_LOAD_C3   = 3'd2;
    localparam logic [2:0] REG_LOAD_C2   = 3'd3;
    localparam logic [2:0] REG_LOAD_C1   = 3'd4;
    localparam logic [2:0] REG_UNLOAD_C3 = 3'd5;
    localparam logic [2:0] REG_UNLOAD_C2 = 3'd6;
    localparam logic [2:0] REG_UNLOAD_C1 = 3'd7;

    localparam logic [23:0]        RST_BASELINE  = 24'd1000000;
    localparam logic [7:0]         RST_STEEPNESS = 8'd20;
    localparam logic signed [23:0] RST_LOAD_C3   = 24'sd783588;
    localparam logic signed [23:0] RST_LOAD_C2   = -24'sd339490;
    localparam logic signed [23:0] RST_LOAD_C1   = 24'sd164987;
    localparam logic signed [23:0] RST_UNLOAD_C3 = -24'sd1004097;
    localparam logic signed [23:0] RST_UNLOAD_C2 = 24'sd225582;
    localparam logic signed [23:0] RST_UNLOAD_C1 = 24'sd137848;

    localparam logic [1:0] STAT_NORMAL  = 2'd0;
    localparam logic [1:0] STAT_NO_HIST = 2'd1;
    localparam logic [1:0] STAT_ZERO_DT = 2'd2;

    typedef struct packed {
        logic [23:0]        baseline;
        logic [7:0]         steepness;
        logic signed [23:0] load_c3;
        logic signed [23:0] load_c2;
        logic signed [23:0] load_c1;
        logic signed [23:0] unload_c3;
        logic signed [23:0] unload_c2;
        logic signed [23:0] unload_c1;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_RC, OP_SL_START, OP_SLOPE, OP_X2, OP_X3, OP_X3R,
        OP_P3, OP_P2, OP_P1, OP_CUBIC, OP_BLEND_L, OP_BLEND_U, OP_ANGLE
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV_RC, ST_RC, ST_SL_START, ST_DIV_SL, ST_SLOPE, ST_X2,
        ST_X3, ST_X3R, ST_P3, ST_P2, ST_P1, ST_CUBIC, ST_BLEND_L, ST_BLEND_U,
        ST_ANGLE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic slope_normal;
        logic out_busy;
    } dp_sts_t;

    // shift-subtract quotient, used only while building the table
    function automatic longint unsigned long_div(input longint unsigned n,
                                                 input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            if (r >= d)
            begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // sigmoid of x in Q16 for 0 <= x <= 8.0
    function automatic sig_word_t sigmoid_pos(input longint unsigned x);
        longint unsigned y;
        longint unsigned term;
        longint          sum;
        longint unsigned a;
        longint unsigned den;
        y    = x << 11;
        term = 64'd1 << 30;
        sum  = 64'sd1 << 30;
        for (int k = 1; k <= 12; k++)
        begin
            term = long_div((term * y) >> 30, 64'(k));
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        a = longint'(sum);
        for (int k = 0; k < 3; k++)
            a = (a * a + (64'd1 << 29)) >> 30;
        den = (64'd1 << 30) + a;
        return sig_word_t'(long_div((64'd1 << 46) + (den >> 1), den));
    endfunction

    function automatic sig_table_t build_sig_table();
        sig_table_t tab;
        longint     x;
        for (int i = 0; i < SIG_ENTRIES; i++)
        begin
            x = longint'(long_div(64'(longint'(i) * 2 * ARG_LIMIT), 64'(SIG_ENTRIES - 1)))
                - ARG_LIMIT;
            if (x >= 0)
                tab[i] = sigmoid_pos(longint'(x));
            else
                tab[i] = sig_word_t'(17'd65536 - sigmoid_pos(longint'(-x)));
        end
        return tab;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

/* rtl/rasm_cfg.sv */
// APB configuration register file.
module rasm_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rasm_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output rasm_pkg::cfg_t                 cfg
);

    rasm_pkg::cfg_t cfg_reg;
    rasm_pkg::cfg_t cfg_next;
    logic [2:0]     idx;
    logic           wr;

    assign idx    = paddr[4:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                rasm_pkg::REG_BASELINE:  cfg_next.baseline  = pwdata[23:0];
                rasm_pkg::REG_STEEPNESS: cfg_next.steepness = pwdata[7:0];
                rasm_pkg::REG_LOAD_C3:   cfg_next.load_c3   = pwdata[23:0];
                rasm_pkg::REG_LOAD_C2:   cfg_next.load_c2   = pwdata[23:0];
                rasm_pkg::REG_LOAD_C1:   cfg_next.load_c1   = pwdata[23:0];
                rasm_pkg::REG_UNLOAD_C3: cfg_next.unload_c3 = pwdata[23:0];
                rasm_pkg::REG_UNLOAD_C2: cfg_next.unload_c2 = pwdata[23:0];
                rasm_pkg::REG_UNLOAD_C1: cfg_next.unload_c1 = pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            rasm_pkg::REG_BASELINE:  prdata = {8'd0, cfg_reg.baseline};
            rasm_pkg::REG_STEEPNESS: prdata = {24'd0, cfg_reg.steepness};
            rasm_pkg::REG_LOAD_C3:   prdata = {8'd0, cfg_reg.load_c3};
            rasm_pkg::REG_LOAD_C2:   prdata = {8'd0, cfg_reg.load_c2};
            rasm_pkg::REG_LOAD_C1:   prdata = {8'd0, cfg_reg.load_c1};
            rasm_pkg::REG_UNLOAD_C3: prdata = {8'd0, cfg_reg.unload_c3};
            rasm_pkg::REG_UNLOAD_C2: prdata = {8'd0, cfg_reg.unload_c2};
            rasm_pkg::REG_UNLOAD_C1: prdata = {8'd0, cfg_reg.unload_c1};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.baseline  <= rasm_pkg::RST_BASELINE;
            cfg_reg.steepness <= rasm_pkg::RST_STEEPNESS;
            cfg_reg.load_c3   <= rasm_pkg::RST_LOAD_C3;
            cfg_reg.load_c2   <= rasm_pkg::RST_LOAD_C2;
            cfg_reg.load_c1   <= rasm_pkg::RST_LOAD_C1;
            cfg_reg.unload_c3 <= rasm_pkg::RST_UNLOAD_C3;
            cfg_reg.unload_c2 <= rasm_pkg::RST_UNLOAD_C2;
            cfg_reg.unload_c1 <= rasm_pkg::RST_UNLOAD_C1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/rasm_div.sv */
// Restoring divider, one quotient bit per cycle.
module rasm_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  rasm_pkg::div_word_t   num,
    input  logic [31:0]           den,
    output rasm_pkg::div_word_t   quot,
    output logic                  done
);

    rasm_pkg::div_word_t             quo_reg, quo_next;
    logic [31:0]                     rem_reg, rem_next;
    logic [31:0]                     den_reg, den_next;
    logic [rasm_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [32:0]                     rem_sh;
    logic                            ge;
    logic [32:0]                     rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[rasm_pkg::DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign quot    = quo_reg;
    assign done    = done_reg;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = num;
            rem_next  = 32'd0;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[rasm_pkg::DIV_W-2:0], ge};
            rem_next = ge ? rem_sub[31:0] : rem_sh[31:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rasm_pkg::DIV_CNT_W'(rasm_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

/* rtl/rasm_ctrl.sv */
// Sequencer for one item through the datapath.
module rasm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rasm_pkg::dp_sts_t   sts,
    output rasm_pkg::dp_cmd_t   cmd
);

    rasm_pkg::ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rasm_pkg::ST_IDLE:     if (in_valid) state_next = rasm_pkg::ST_DIV_RC;
            rasm_pkg::ST_DIV_RC:   if (sts.div_done) state_next = rasm_pkg::ST_RC;
            rasm_pkg::ST_RC:       state_next = rasm_pkg::ST_SL_START;
            rasm_pkg::ST_SL_START: state_next = sts.slope_normal ? rasm_pkg::ST_DIV_SL
                                                                 : rasm_pkg::ST_SLOPE;
            rasm_pkg::ST_DIV_SL:   if (sts.div_done) state_next = rasm_pkg::ST_SLOPE;
            rasm_pkg::ST_SLOPE:    state_next = rasm_pkg::ST_X2;
            rasm_pkg::ST_X2:       state_next = rasm_pkg::ST_X3;
            rasm_pkg::ST_X3:       state_next = rasm_pkg::ST_X3R;
            rasm_pkg::ST_X3R:      state_next = rasm_pkg::ST_P3;
            rasm_pkg::ST_P3:       state_next = rasm_pkg::ST_P2;
            rasm_pkg::ST_P2:       state_next = rasm_pkg::ST_P1;
            rasm_pkg::ST_P1:       state_next = rasm_pkg::ST_CUBIC;
            rasm_pkg::ST_CUBIC:    state_next = rasm_pkg::ST_BLEND_L;
            rasm_pkg::ST_BLEND_L:  state_next = rasm_pkg::ST_BLEND_U;
            rasm_pkg::ST_BLEND_U:  state_next = rasm_pkg::ST_ANGLE;
            rasm_pkg::ST_ANGLE:    if (!sts.out_busy) state_next = rasm_pkg::ST_IDLE;
            default:               state_next = rasm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = rasm_pkg::OP_NONE;
        case (state_reg)
            rasm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = rasm_pkg::OP_LOAD;
            end
            rasm_pkg::ST_DIV_RC:   cmd.op = rasm_pkg::OP_NONE;
            rasm_pkg::ST_RC:       cmd.op = rasm_pkg::OP_RC;
            rasm_pkg::ST_SL_START: cmd.op = rasm_pkg::OP_SL_START;
            rasm_pkg::ST_DIV_SL:   cmd.op = rasm_pkg::OP_NONE;
            rasm_pkg::ST_SLOPE:    cmd.op = rasm_pkg::OP_SLOPE;
            rasm_pkg::ST_X2:       cmd.op = rasm_pkg::OP_X2;
            rasm_pkg::ST_X3:       cmd.op = rasm_pkg::OP_X3;
            rasm_pkg::ST_X3R:      cmd.op = rasm_pkg::OP_X3R;
            rasm_pkg::ST_P3:       cmd.op = rasm_pkg::OP_P3;
            rasm_pkg::ST_P2:       cmd.op = rasm_pkg::OP_P2;
            rasm_pkg::ST_P1:       cmd.op = rasm_pkg::OP_P1;
            rasm_pkg::ST_CUBIC:    cmd.op = rasm_pkg::OP_CUBIC;
            rasm_pkg::ST_BLEND_L:  cmd.op = rasm_pkg::OP_BLEND_L;
            rasm_pkg::ST_BLEND_U:  cmd.op = rasm_pkg::OP_BLEND_U;
            rasm_pkg::ST_ANGLE:    if (!sts.out_busy) cmd.op = rasm_pkg::OP_ANGLE;
            default:               cmd.op = rasm_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rasm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/rasm_dp.sv */
// Datapath: relative change, slope, sigmoid blend of the two cubics.
module rasm_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  rasm_pkg::cfg_t      cfg,
    input  rasm_pkg::dp_cmd_t   cmd,
    output rasm_pkg::dp_sts_t   sts,
    input  logic [23:0]         resistance,
    input  logic [31:0]         sample_time,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [19:0]  angle,
    output logic signed [19:0]  relative_change,
    output logic [1:0]          status
);

    function automatic logic signed [47:0] rnd16(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] q;
        mag = v[63] ? 64'(-v) : 64'(v);
        q   = (mag + 64'd32768) >> 16;
        return v[63] ? -$signed(q[47:0]) : $signed(q[47:0]);
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [47:0] v);
        if (v > 48'sd524287)
            return 20'sd524287;
        else if (v < -48'sd524288)
            return -20'sd524288;
        else
            return v[19:0];
    endfunction

    // history and per-item state
    logic signed [19:0]  prev_change_reg;
    logic [31:0]         prev_time_reg;
    logic                hist_reg;
    logic [31:0]         time_reg;
    logic                neg_reg;
    logic signed [19:0]  rc_reg;
    logic [31:0]         dt_reg;
    logic [1:0]          status_reg;
    logic signed [21:0]  slope_reg;
    logic signed [40:0]  x2p_reg;
    logic signed [23:0]  x2_reg;
    logic signed [29:0]  arg_reg;
    logic signed [43:0]  x3p_reg;
    logic [20:0]         argoff_reg;
    logic signed [26:0]  x3_reg;
    rasm_pkg::idxp_t     idxp_reg;
    logic [16:0]         w_reg;
    logic signed [55:0]  accl_reg;
    logic signed [55:0]  accu_reg;
    logic signed [39:0]  lv_reg;
    logic signed [39:0]  uv_reg;
    logic signed [57:0]  bl_reg;
    logic                out_valid_reg;
    logic signed [19:0]  angle_reg;
    logic signed [19:0]  rc_out_reg;
    logic [1:0]          status_out_reg;

    logic [23:0]               r0;
    logic signed [24:0]        diff;
    logic [23:0]               diff_mag;
    rasm_pkg::div_word_t       rc_num;
    logic signed [20:0]        dchg;
    logic [20:0]               dmag;
    rasm_pkg::div_word_t       sl_num;
    rasm_pkg::div_word_t       div_num;
    logic [31:0]               div_den;
    logic                      div_start;
    rasm_pkg::div_word_t       quot;
    logic                      div_done;
    logic [31:0]               dt;
    logic signed [19:0]        rc_sat;
    logic [20:0]               smag;
    logic signed [29:0]        arg_clamp;
    logic [29:0]               arg_sum;
    logic [rasm_pkg::SIG_IDX_W-1:0] idx;
    logic [16:0]               wc;
    logic signed [47:0]        x2_rnd, x3_rnd, lv_rnd, uv_rnd, ang_rnd;
    logic                      normal;

    assign r0       = (cfg.baseline == 24'd0) ? 24'd1 : cfg.baseline;
    assign diff     = $signed({1'b0, resistance}) - $signed({1'b0, r0});
    assign diff_mag = diff[24] ? 24'(-diff) : diff[23:0];
    assign rc_num   = {2'b0, diff_mag, 16'd0} + rasm_pkg::div_word_t'(r0 >> 1);

    assign dchg   = 21'(rc_reg) - 21'(prev_change_reg);
    assign dmag   = dchg[20] ? 21'(-dchg) : dchg[20:0];
    assign sl_num = rasm_pkg::div_word_t'(dmag) * rasm_pkg::div_word_t'(rasm_pkg::SLOPE_SCALE)
                    + rasm_pkg::div_word_t'(dt_reg >> 1);

    assign normal    = status_reg == rasm_pkg::STAT_NORMAL;
    assign div_start = (cmd.op == rasm_pkg::OP_LOAD) ||
                       ((cmd.op == rasm_pkg::OP_SL_START) && normal);
    assign div_num   = (cmd.op == rasm_pkg::OP_LOAD) ? rc_num : sl_num;
    assign div_den   = (cmd.op == rasm_pkg::OP_LOAD) ? {8'd0, r0} : dt_reg;

    rasm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (quot),
        .done  (div_done)
    );

    assign dt = time_reg - prev_time_reg;

    always_comb
    begin
        if (neg_reg)
            rc_sat = (quot > rasm_pkg::div_word_t'(524288)) ? -20'sd524288 : 20'(-quot);
        else
            rc_sat = (quot > rasm_pkg::div_word_t'(524287)) ? 20'sd524287 : quot[19:0];
    end

    assign smag = (quot > rasm_pkg::div_word_t'(1048576)) ? 21'd1048576 : quot[20:0];

    always_comb
    begin
        if (arg_reg > 30'sd524288)
            arg_clamp = 30'sd524288;
        else if (arg_reg < -30'sd524288)
            arg_clamp = -30'sd524288;
        else
            arg_clamp = arg_reg;
    end

    assign arg_sum = arg_clamp + 30'sd524288;
    assign idx     = idxp_reg[rasm_pkg::SIG_IDX_W+19:20];
    assign wc      = 17'd65536 - w_reg;

    assign x2_rnd  = rnd16(64'(x2p_reg));
    assign x3_rnd  = rnd16(64'(x3p_reg));
    assign lv_rnd  = rnd16(64'(accl_reg));
    assign uv_rnd  = rnd16(64'(accu_reg));
    assign ang_rnd = rnd16(64'(bl_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_change_reg <= '0;
            prev_time_reg   <= '0;
            hist_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.op == rasm_pkg::OP_SL_START)
            begin
                prev_change_reg <= rc_reg;
                prev_time_reg   <= time_reg;
                hist_reg        <= 1'b1;
            end
            if (cmd.op == rasm_pkg::OP_ANGLE)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            rasm_pkg::OP_LOAD:
            begin
                time_reg <= sample_time;
                neg_reg  <= diff[24];
            end
            rasm_pkg::OP_RC:
            begin
                rc_reg <= rc_sat;
                dt_reg <= dt;
                if (!hist_reg)
                    status_reg <= rasm_pkg::STAT_NO_HIST;
                else if (dt == 32'd0)
                    status_reg <= rasm_pkg::STAT_ZERO_DT;
                else
                    status_reg <= rasm_pkg::STAT_NORMAL;
            end
            rasm_pkg::OP_SL_START: neg_reg <= dchg[20];
            rasm_pkg::OP_SLOPE:
            begin
                if (normal)
                    slope_reg <= neg_reg ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
                else
                    slope_reg <= '0;
                x2p_reg <= 41'(rc_reg) * 41'(rc_reg);
            end
            rasm_pkg::OP_X2:
            begin
                x2_reg  <= x2_rnd[23:0];
                arg_reg <= 30'($signed({1'b0, cfg.steepness})) * 30'(slope_reg);
            end
            rasm_pkg::OP_X3:
            begin
                x3p_reg    <= 44'(x2_reg) * 44'(rc_reg);
                argoff_reg <= arg_sum[20:0];
            end
            rasm_pkg::OP_X3R:
            begin
                x3_reg   <= x3_rnd[26:0];
                idxp_reg <= rasm_pkg::idxp_t'(argoff_reg)
                            * rasm_pkg::idxp_t'(rasm_pkg::SIG_ENTRIES - 1)
                            + rasm_pkg::idxp_t'(rasm_pkg::ARG_LIMIT);
            end
            rasm_pkg::OP_P3:
            begin
                accl_reg <= 56'(cfg.load_c3) * 56'(x3_reg);
                accu_reg <= 56'(cfg.unload_c3) * 56'(x3_reg);
                w_reg    <= rasm_pkg::SIG_TABLE[idx];
            end
            rasm_pkg::OP_P2:
            begin
                accl_reg <= accl_reg + 56'(cfg.load_c2) * 56'(x2_reg);
                accu_reg <= accu_reg + 56'(cfg.unload_c2) * 56'(x2_reg);
            end
            rasm_pkg::OP_P1:
            begin
                accl_reg <= accl_reg + 56'(cfg.load_c1) * 56'(rc_reg);
                accu_reg <= accu_reg + 56'(cfg.unload_c1) * 56'(rc_reg);
            end
            rasm_pkg::OP_CUBIC:
            begin
                lv_reg <= lv_rnd[39:0];
                uv_reg <= uv_rnd[39:0];
            end
            rasm_pkg::OP_BLEND_L: bl_reg <= 58'($signed({1'b0, w_reg})) * 58'(lv_reg);
            rasm_pkg::OP_BLEND_U: bl_reg <= bl_reg + 58'($signed({1'b0, wc})) * 58'(uv_reg);
            rasm_pkg::OP_ANGLE:
            begin
                angle_reg      <= sat20(ang_rnd);
                rc_out_reg     <= rc_reg;
                status_out_reg <= status_reg;
            end
            default: ;
        endcase
    end

    assign sts.div_done     = div_done;
    assign sts.slope_normal = normal;
    assign sts.out_busy     = out_valid_reg & ~out_ready;

    assign out_valid       = out_valid_reg;
    assign angle           = angle_reg;
    assign relative_change = rc_out_reg;
    assign status          = status_out_reg;

endmodule

/* rtl/resistance_angle_switching_model_core.sv */
// Top level: strain-sensor resistance to bend angle estimator.
//
//   channel | direction | handshake            | payload
//   cfg     | in/out    | psel/penable/pready  | paddr, pwdata, prdata
//   in      | in        | in_valid/in_ready    | resistance, sample_time
//   out     | out       | out_valid/out_ready  | angle, relative_change, status
//
// One item at a time; between one accept and the next an item passes two divider
// waits and 14 sequencer steps; the second divider wait is skipped when there
// is no history or the time step is zero. The divider waits take most of that time.
// Reset clears history and the output valid and loads the config defaults.
// A finished result sits in the output register; the next item is taken
// meanwhile and stalls only in its last step until that result is taken.
module resistance_angle_switching_model_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rasm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [23:0]                   resistance,
    input  logic [31:0]                   sample_time,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [19:0]            angle,
    output logic signed [19:0]            relative_change,
    output logic [1:0]                    status
);

    rasm_pkg::cfg_t     cfg;
    rasm_pkg::dp_cmd_t  cmd;
    rasm_pkg::dp_sts_t  sts;

    rasm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rasm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rasm_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .sts             (sts),
        .resistance      (resistance),
        .sample_time     (sample_time),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .angle           (angle),
        .relative_change (relative_change),
        .status          (status)
    );

endmodule
